/* rtl/stable_sorted_priority_queue_top_assert.svh */
// Assertion macros used by the priority queue controller
`ifndef STABLE_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, clocked on aclk, quiet during reset
`define SSPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sspq_pkg.sv */
// Package: constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
package sspq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int CODE_W = 10;
    localparam int PRIO_W = 5;
    localparam int STAT_W = 2;

    localparam logic [CODE_W-1:0] CODE_MIN = 10'd100;
    localparam logic [CODE_W-1:0] CODE_MAX = 10'd999;
    localparam logic [PRIO_W-1:0] PRIO_MIN = 5'd1;
    localparam logic [PRIO_W-1:0] PRIO_MAX = 5'd20;

    localparam logic CMD_INSERT   = 1'b0;
    localparam logic CMD_TRAVERSE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic              insert;
        logic              trav_start;
        logic              rotate;
        logic              load;
        logic              sel_entry;
        logic [STAT_W-1:0] status;
        logic              last;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic entry_ok;
        logic at_tail;
    } dp_sts_t;

endpackage

/* rtl/sspq_datapath.sv */
// Datapath: sorted entry chain, entry count, walk counter and result register
`timescale 1ns / 1ps
module sspq_datapath #(
    parameter int DEPTH = sspq_pkg::DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [sspq_pkg::CODE_W-1:0] in_code,
    input  logic [sspq_pkg::PRIO_W-1:0] in_prio,
    input  sspq_pkg::dp_cmd_t           cmd,
    output sspq_pkg::dp_sts_t           sts,
    output logic [sspq_pkg::STAT_W-1:0] out_status,
    output logic [sspq_pkg::CODE_W-1:0] out_code,
    output logic [sspq_pkg::PRIO_W-1:0] out_prio,
    output logic                        out_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [sspq_pkg::CODE_W-1:0] code_reg  [DEPTH];
    logic [sspq_pkg::CODE_W-1:0] code_next [DEPTH];
    logic [sspq_pkg::PRIO_W-1:0] prio_reg  [DEPTH];
    logic [sspq_pkg::PRIO_W-1:0] prio_next [DEPTH];
    logic [sspq_pkg::CODE_W-1:0] up_code   [DEPTH];
    logic [sspq_pkg::PRIO_W-1:0] up_prio   [DEPTH];
    logic [sspq_pkg::CODE_W-1:0] dn_code   [DEPTH];
    logic [sspq_pkg::PRIO_W-1:0] dn_prio   [DEPTH];
    logic [DEPTH-1:0]            gt;
    logic [DEPTH-1:0]            up_gt;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] walk_reg, walk_next;

    logic [sspq_pkg::STAT_W-1:0] status_reg;
    logic [sspq_pkg::CODE_W-1:0] ocode_reg;
    logic [sspq_pkg::PRIO_W-1:0] oprio_reg;
    logic                        olast_reg;

    // neighbour taps of each cell
    for (genvar i = 0; i < DEPTH; i++) begin : g_tap
        assign gt[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] > in_prio);
        if (i == 0) begin : g_head
            assign up_gt[i]   = 1'b0;
            assign up_code[i] = code_reg[i];
            assign up_prio[i] = prio_reg[i];
        end else begin : g_body
            assign up_gt[i]   = gt[i-1];
            assign up_code[i] = code_reg[i-1];
            assign up_prio[i] = prio_reg[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign dn_code[i] = code_reg[0];
            assign dn_prio[i] = prio_reg[0];
        end else begin : g_mid
            assign dn_code[i] = code_reg[i+1];
            assign dn_prio[i] = prio_reg[i+1];
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            code_next[i] = code_reg[i];
            prio_next[i] = prio_reg[i];
            if (cmd.insert) begin
                if (up_gt[i]) begin
                    code_next[i] = up_code[i];
                    prio_next[i] = up_prio[i];
                end else if (gt[i] || (CNT_W'(i) == count_reg)) begin
                    code_next[i] = in_code;
                    prio_next[i] = in_prio;
                end
            end else if (cmd.rotate && (CNT_W'(i) < count_reg)) begin
                if (CNT_W'(i) == count_reg - CNT_W'(1)) begin
                    code_next[i] = code_reg[0];
                    prio_next[i] = prio_reg[0];
                end else begin
                    code_next[i] = dn_code[i];
                    prio_next[i] = dn_prio[i];
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end
        walk_next = walk_reg;
        if (cmd.trav_start) begin
            walk_next = '0;
        end else if (cmd.rotate) begin
            walk_next = walk_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            code_reg[i] <= code_next[i];
            prio_reg[i] <= prio_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            walk_reg  <= '0;
        end else begin
            count_reg <= count_next;
            walk_reg  <= walk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status_reg <= cmd.status;
            olast_reg  <= cmd.last;
            ocode_reg  <= cmd.sel_entry ? code_reg[0] : '0;
            oprio_reg  <= cmd.sel_entry ? prio_reg[0] : '0;
        end
    end

    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CNT_W'(DEPTH));
    assign sts.entry_ok = (in_code >= sspq_pkg::CODE_MIN) && (in_code <= sspq_pkg::CODE_MAX)
                       && (in_prio >= sspq_pkg::PRIO_MIN) && (in_prio <= sspq_pkg::PRIO_MAX);
    assign sts.at_tail  = (walk_reg == count_reg - CNT_W'(1));

    assign out_status = status_reg;
    assign out_code   = ocode_reg;
    assign out_prio   = oprio_reg;
    assign out_last   = olast_reg;

endmodule

/* rtl/sspq_ctrl.sv */
// Controller: request sequencing, traverse walk and result-valid flag
`timescale 1ns / 1ps
`include "stable_sorted_priority_queue_top_assert.svh"
module sspq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_cmd,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  sspq_pkg::dp_sts_t sts,
    output sspq_pkg::dp_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TRAV = 1'b1;

    logic state_reg, state_next;
    logic mvalid_reg, mvalid_next;
    logic out_free;
    logic accept;

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    cmd.last = 1'b1;
                    if (in_cmd == sspq_pkg::CMD_TRAVERSE) begin
                        if (sts.empty) begin
                            cmd.status = sspq_pkg::ST_EMPTY;
                        end else begin
                            cmd.load       = 1'b0;
                            cmd.last       = 1'b0;
                            cmd.trav_start = 1'b1;
                            state_next     = ST_TRAV;
                        end
                    end else if (!sts.entry_ok) begin
                        cmd.status = sspq_pkg::ST_INVALID;
                    end else if (sts.full) begin
                        cmd.status = sspq_pkg::ST_FULL;
                    end else begin
                        cmd.status = sspq_pkg::ST_OK;
                        cmd.insert = 1'b1;
                    end
                end
            end
            ST_TRAV: begin
                if (out_free) begin
                    cmd.load      = 1'b1;
                    cmd.sel_entry = 1'b1;
                    cmd.rotate    = 1'b1;
                    cmd.status    = sspq_pkg::ST_OK;
                    cmd.last      = sts.at_tail;
                    if (sts.at_tail) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

    `SSPQ_ASSERT_NOW(a_no_overwrite, mvalid_reg && !m_tready, !cmd.load, "result overwritten")
    `SSPQ_ASSERT_NOW(a_insert_legal, cmd.insert, sts.entry_ok && !sts.full, "bad insert")
    `SSPQ_ASSERT_NOW(a_trav_blocks, state_reg == ST_TRAV, !s_tready, "request taken mid-walk")
    `SSPQ_ASSERT_NEXT(a_tail_ends, (state_reg == ST_TRAV) && cmd.load && cmd.last, state_reg == ST_IDLE, "walk overran tail")

endmodule

/* rtl/stable_sorted_priority_queue_top.sv */
// Top level: stable sorted priority queue with streaming ports
// Insert: one request per cycle while idle and the result port is free; the
// status shows in the cycle after acceptance. Traverse: a setup step, then
// one entry per cycle while the port is free, set by the rotating entry
// chain showing its head. Empty traverse, invalid or full insert: one result.
// Synchronous active-low reset empties the store; no clearing pass is needed.
`timescale 1ns / 1ps
module stable_sorted_priority_queue_top #(
    parameter int DEPTH = sspq_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] entry_code, [14:10] entry_priority, [15] zero
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] out_code, [14:10] out_priority, [15] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    sspq_pkg::dp_cmd_t cmd;
    sspq_pkg::dp_sts_t sts;

    logic [sspq_pkg::CODE_W-1:0] out_code;
    logic [sspq_pkg::PRIO_W-1:0] out_prio;

    sspq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sspq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_code    (s_tdata[9:0]),
        .in_prio    (s_tdata[14:10]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (m_tuser),
        .out_code   (out_code),
        .out_prio   (out_prio),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_prio, out_code};

endmodule
